// ===== hdl/cal_pkg.sv =====
// Shared types and codes for the cursor array list.
// Used by cal_cell and cursor_array_list_unit; depends on nothing.
package cal_pkg;

    // Request action codes
    typedef enum logic [2:0] {
        ACT_INS_BEFORE = 3'd0,
        ACT_INS_AFTER  = 3'd1,
        ACT_DELETE     = 3'd2,
        ACT_PREV       = 3'd3,
        ACT_NEXT       = 3'd4,
        ACT_FIRST      = 3'd5,
        ACT_LAST       = 3'd6,
        ACT_READ       = 3'd7
    } cal_action_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_BAD_INDEX = 3'd2,
        ST_FULL      = 3'd3,
        ST_AT_END    = 3'd4
    } cal_status_t;

    // Command broadcast along the row of cells
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2
    } cal_cell_op_t;

endpackage

// ===== hdl/cal_cell.sv =====
// One storage cell of the cursor array list row.
// Depends on cal_pkg for the broadcast command type.
module cal_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 4,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  cal_pkg::cal_cell_op_t op,
    input  logic [IDX_W-1:0]      slot,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic [IDX_W-1:0]      rd_idx,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] rd_data
);
    import cal_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    // Pick the new content: take the new value, shift from a neighbour or hold
    always_comb
    begin
        data_next = data_reg;
        case (op)
            CELL_INSERT:
            begin
                if (MY_IDX == slot)
                    data_next = value;
                else if (MY_IDX > slot)
                    data_next = left_data;
            end
            CELL_DELETE:
            begin
                if (MY_IDX >= slot)
                    data_next = right_data;
            end
            default:
                data_next = data_reg;
        endcase
    end

    // Payload register, no reset needed
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    // Drive the shared read bus only when addressed
    assign rd_data = (rd_idx == MY_IDX) ? data_reg : '0;

endmodule

// ===== hdl/cursor_array_list_unit.sv =====
// Cursor array list: a row of shifting cells plus cursor and count control.
// Depends on cal_pkg and cal_cell.
// An accepted request waits in the pending register, then its result is loaded
// from the updated row into the output register. One request per cycle unless the
// output stalls; every cell shifts in the same cycle as the request is accepted.
// Reset: count and cursor clear; entry contents are unknown until written.
module cursor_array_list_unit #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32,
    localparam int IDX_W     = $clog2(CAPACITY),
    localparam int CNT_W     = $clog2(CAPACITY + 1),
    localparam int IN_BITS   = 3 + DATA_WIDTH + IDX_W,
    localparam int IN_TW     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS  = 3 + DATA_WIDTH + CNT_W + IDX_W,
    localparam int OUT_TW    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // action[2:0], value, position (zero padded to whole bytes)
    input  logic [IN_TW-1:0]  s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // status[2:0], read_value, entry_count, cursor_position (zero padded)
    output logic [OUT_TW-1:0] m_tdata
);
    import cal_pkg::*;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Request fields
    cal_action_t           in_action;
    logic [DATA_WIDTH-1:0] in_value;
    logic [IDX_W-1:0]      in_pos;

    assign in_action = cal_action_t'(s_tdata[2:0]);
    assign in_value  = s_tdata[3 +: DATA_WIDTH];
    assign in_pos    = s_tdata[3 + DATA_WIDTH +: IDX_W];

    // Control state
    logic [CNT_W-1:0] len_reg, len_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic             pend_reg;
    cal_status_t      pend_status_reg, status_next;
    logic             pend_zero_reg, zero_next;
    logic [IDX_W-1:0] pend_idx_reg, idx_next;

    // Output register
    logic                  out_valid_reg;
    cal_status_t           out_status_reg;
    logic [DATA_WIDTH-1:0] out_value_reg;
    logic [CNT_W-1:0]      out_len_reg;
    logic [IDX_W-1:0]      out_cur_reg;

    logic         accept;
    logic         out_free;
    logic         out_load;
    cal_cell_op_t cell_op;
    logic [IDX_W-1:0] cell_slot;
    logic         is_empty;
    logic         is_read;

    assign out_free = !out_valid_reg || m_tready;
    assign out_load = pend_reg && out_free;
    assign s_tready = !pend_reg || out_free;
    assign accept   = s_tvalid && s_tready;
    assign is_empty = (len_reg == '0);

    // Decode the request into a cell command and the next count and cursor
    always_comb
    begin
        len_next    = len_reg;
        cur_next    = cur_reg;
        status_next = ST_OK;
        cell_op     = CELL_HOLD;
        cell_slot   = cur_reg;
        is_read     = 1'b0;
        case (in_action)
            ACT_INS_BEFORE, ACT_INS_AFTER:
            begin
                if (is_empty)
                begin
                    cell_op   = CELL_INSERT;
                    cell_slot = '0;
                    len_next  = CNT_W'(1);
                    cur_next  = '0;
                end
                else if (len_reg >= CAP_CNT)
                begin
                    status_next = ST_FULL;
                end
                else if (in_action == ACT_INS_BEFORE)
                begin
                    cell_op   = CELL_INSERT;
                    cell_slot = cur_reg;
                    len_next  = len_reg + CNT_W'(1);
                    cur_next  = cur_reg + IDX_W'(1);
                end
                else
                begin
                    cell_op   = CELL_INSERT;
                    cell_slot = cur_reg + IDX_W'(1);
                    len_next  = len_reg + CNT_W'(1);
                end
            end
            ACT_DELETE:
            begin
                if (is_empty)
                    status_next = ST_EMPTY;
                else
                begin
                    cell_op   = CELL_DELETE;
                    cell_slot = cur_reg;
                    len_next  = len_reg - CNT_W'(1);
                    if (len_next == '0)
                        cur_next = '0;
                    else if (CNT_W'(cur_reg) == len_next)
                        cur_next = cur_reg - IDX_W'(1);
                end
            end
            ACT_PREV:
            begin
                if (is_empty)
                    status_next = ST_EMPTY;
                else if (cur_reg == '0)
                    status_next = ST_AT_END;
                else
                    cur_next = cur_reg - IDX_W'(1);
            end
            ACT_NEXT:
            begin
                if (is_empty)
                    status_next = ST_EMPTY;
                else if ((CNT_W'(cur_reg) + CNT_W'(1)) >= len_reg)
                    status_next = ST_AT_END;
                else
                    cur_next = cur_reg + IDX_W'(1);
            end
            ACT_FIRST:
            begin
                if (is_empty)
                    status_next = ST_EMPTY;
                else
                    cur_next = '0;
            end
            ACT_LAST:
            begin
                if (is_empty)
                    status_next = ST_EMPTY;
                else
                    cur_next = IDX_W'(len_reg - CNT_W'(1));
            end
            default:
            begin
                is_read = 1'b1;
                if (is_empty)
                    status_next = ST_EMPTY;
                else if (CNT_W'(in_pos) >= len_reg)
                    status_next = ST_BAD_INDEX;
            end
        endcase

        if (!accept)
            cell_op = CELL_HOLD;

        // Address and blanking of the value read back after the update
        idx_next  = is_read ? in_pos : cur_next;
        zero_next = (status_next == ST_EMPTY) || (status_next == ST_BAD_INDEX) ||
                    (!is_read && (len_next == '0));
    end

    // Row of cells
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = in_value;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        cal_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .op         (cell_op),
            .slot       (cell_slot),
            .value      (in_value),
            .rd_idx     (pend_idx_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    // Merge the read bus of all cells
    logic [DATA_WIDTH-1:0] rd_merged;

    always_comb
    begin
        rd_merged = '0;
        for (int k = 0; k < CAPACITY; k++)
            rd_merged = rd_merged | cell_rd[k];
    end

    // Hold count, cursor and the pending request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            cur_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                len_reg  <= len_next;
                cur_reg  <= cur_next;
                pend_reg <= 1'b1;
            end
            else if (out_load)
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_status_reg <= status_next;
            pend_zero_reg   <= zero_next;
            pend_idx_reg    <= idx_next;
        end
    end

    // Output register: load the pending result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= pend_status_reg;
            out_value_reg  <= pend_zero_reg ? '0 : rd_merged;
            out_len_reg    <= len_reg;
            out_cur_reg    <= cur_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TW'({out_cur_reg, out_len_reg, out_value_reg, out_status_reg});

`ifndef SYNTHESIS
    a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != '0) |-> (CNT_W'(cur_reg) < len_reg))
        else $error("cursor beyond the last entry");

    a_cur_zero_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg == '0) |-> (cur_reg == '0))
        else $error("cursor not at zero on an empty list");

    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_out_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pend_reg))
        else $error("result presented without a pending request");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for cursor_array_list_unit: drives list requests over the input stream
// and checks every reply against an in-bench model of the list, cursor and count.
// Depends on cal_pkg and the RTL of cursor_array_list_unit.
module tb;
    import cal_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH = 16;
    localparam int IDLE_PCT   = 21;

    // One reply as packed on m_tdata, lowest field last
    typedef struct packed {
        logic [3:0]  cursor_position;
        logic [4:0]  entry_count;
        logic [31:0] read_value;
        cal_status_t status;
    } list_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // action[2:0], value[31:0], position[3:0], zero pad
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // status[2:0], read_value[31:0], entry_count[4:0], cursor_position[3:0], zero pad
    logic [47:0] m_tdata;

    // Bench copy of the list state
    logic [31:0] list_mem [LIST_DEPTH];
    int          list_len = 0;
    int          list_cur = 0;

    list_reply_t expected_replies [$];
    int          error_count = 0;
    bit          no_idle = 1'b0;

    cursor_array_list_unit #(
        .CAPACITY   (LIST_DEPTH),
        .DATA_WIDTH (32)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit take_break();
        return !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // Stall the reply side at random
    always @(posedge clk)
    begin
        m_tready <= !take_break();
    end

    // Apply one request to the bench list and work out its reply
    function automatic list_reply_t predict_list_op(input cal_action_t act,
                                                     input logic [31:0] val,
                                                     input logic [3:0] pos);
        list_reply_t rep;
        bit          is_read;
        int          slot;
        int          i;
        rep = '0;
        rep.status = ST_OK;
        is_read = 1'b0;
        if (list_len == 0 && act != ACT_INS_BEFORE && act != ACT_INS_AFTER)
        begin
            rep.status = ST_EMPTY;
        end
        else
        begin
            case (act)
                ACT_INS_BEFORE, ACT_INS_AFTER:
                begin
                    if (list_len == 0)
                    begin
                        list_mem[0] = val;
                        list_cur = 0;
                        list_len = 1;
                    end
                    else if (list_len >= LIST_DEPTH)
                    begin
                        rep.status = ST_FULL;
                    end
                    else
                    begin
                        // shift later entries up and drop the value into the gap
                        slot = (act == ACT_INS_BEFORE) ? list_cur : list_cur + 1;
                        for (i = list_len; i > slot; i--)
                            list_mem[i] = list_mem[i - 1];
                        list_mem[slot] = val;
                        list_len++;
                        if (act == ACT_INS_BEFORE)
                            list_cur++;
                    end
                end
                ACT_DELETE:
                begin
                    for (i = list_cur; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                    if (list_len > 0 && list_cur == list_len)
                        list_cur--;
                    if (list_len == 0)
                        list_cur = 0;
                end
                ACT_PREV:
                begin
                    if (list_cur == 0)
                        rep.status = ST_AT_END;
                    else
                        list_cur--;
                end
                ACT_NEXT:
                begin
                    if (list_cur + 1 >= list_len)
                        rep.status = ST_AT_END;
                    else
                        list_cur++;
                end
                ACT_FIRST:
                    list_cur = 0;
                ACT_LAST:
                    list_cur = list_len - 1;
                default:
                begin
                    is_read = 1'b1;
                    if (int'(pos) >= list_len)
                        rep.status = ST_BAD_INDEX;
                    else
                        rep.read_value = list_mem[pos];
                end
            endcase
        end
        if (!is_read && rep.status != ST_EMPTY && list_len > 0)
            rep.read_value = list_mem[list_cur];
        rep.entry_count = list_len[4:0];
        rep.cursor_position = list_cur[3:0];
        return rep;
    endfunction

    // Send one request, idling first at random, and record its reply once accepted
    task automatic send_request(input cal_action_t act, input logic [31:0] val,
                                input logic [3:0] pos);
        while (take_break())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, pos, val, act};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_replies.push_back(predict_list_op(act, val, pos));
    endtask

    // Pick one request: inserts and deletes by percentage, the rest spread over moves and reads
    task automatic random_request(input int ins_pct, input int del_pct);
        int          roll;
        logic [3:0]  pos;
        cal_action_t act;
        roll = $urandom_range(0, 99);
        pos = 4'($urandom_range(0, 15));
        if (roll < ins_pct)
            act = ($urandom_range(0, 1) != 0) ? ACT_INS_AFTER : ACT_INS_BEFORE;
        else if (roll < ins_pct + del_pct)
            act = ACT_DELETE;
        else
        begin
            case ($urandom_range(0, 4))
                0: act = ACT_PREV;
                1: act = ACT_NEXT;
                2: act = ACT_FIRST;
                3: act = ACT_LAST;
                default:
                begin
                    act = ACT_READ;
                    // mostly valid indices, some past the end
                    if (list_len > 0 && $urandom_range(0, 3) != 0)
                        pos = 4'($urandom_range(0, list_len - 1));
                end
            endcase
        end
        send_request(act, $urandom(), pos);
    endtask

    // Every non-insert action on an empty list
    task automatic test_empty_list();
        send_request(ACT_DELETE, 32'h0, 4'd0);
        send_request(ACT_PREV, 32'h0, 4'd0);
        send_request(ACT_NEXT, 32'h0, 4'd0);
        send_request(ACT_FIRST, 32'h0, 4'd0);
        send_request(ACT_LAST, 32'h0, 4'd0);
        send_request(ACT_READ, 32'h0, 4'd0);
        send_request(ACT_READ, 32'h0, 4'd15);
    endtask

    // Cursor edges, insert placement, bad index and delete at the tail
    task automatic test_cursor_edges();
        send_request(ACT_INS_BEFORE, 32'hFFFF_FFFF, 4'd0);
        send_request(ACT_PREV, 32'h0, 4'd0);
        send_request(ACT_INS_AFTER, 32'h0000_0000, 4'd0);
        send_request(ACT_NEXT, 32'h0, 4'd0);
        send_request(ACT_NEXT, 32'h0, 4'd0);
        send_request(ACT_INS_BEFORE, 32'h1234_5678, 4'd0);
        send_request(ACT_READ, 32'h0, 4'd15);
        send_request(ACT_READ, 32'h0, 4'd0);
        send_request(ACT_FIRST, 32'h0, 4'd0);
        send_request(ACT_LAST, 32'h0, 4'd0);
        send_request(ACT_DELETE, 32'h0, 4'd0);
        send_request(ACT_DELETE, 32'h0, 4'd0);
        send_request(ACT_DELETE, 32'h0, 4'd0);
    endtask

    // Fill to capacity, push past it, wander, then drain to empty
    task automatic test_fill_and_drain(input int rounds);
        int r;
        int k;
        for (r = 0; r < rounds; r++)
        begin
            while (list_len < LIST_DEPTH)
                random_request(85, 5);
            send_request(ACT_INS_BEFORE, $urandom(), 4'd0);
            send_request(ACT_INS_AFTER, $urandom(), 4'd0);
            send_request(ACT_READ, 32'h0, 4'd15);
            for (k = 0; k < 8; k++)
                random_request(10, 0);
            while (list_len > 0)
                random_request(5, 80);
            random_request(0, 50);
        end
    endtask

    // Unbiased mix, the first stretch with no idling on either side
    task automatic test_random_mix(input int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            no_idle = (n < 80);
            random_request(40, 20);
        end
        no_idle = 1'b0;
    endtask

    // Check each reply against the oldest expectation
    always @(posedge clk)
    begin : reply_check
        list_reply_t got;
        list_reply_t want;
        if (m_tvalid && m_tready)
        begin
            got = m_tdata[43:0];
            if (expected_replies.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected reply: status=%0d value=%h count=%0d cursor=%0d",
                             got.status, got.read_value, got.entry_count,
                             got.cursor_position);
            end
            else
            begin
                want = expected_replies.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"mismatch: expected status=%0d value=%h count=%0d ",
                                  "cursor=%0d, got status=%0d value=%h count=%0d cursor=%0d"},
                                 want.status, want.read_value, want.entry_count,
                                 want.cursor_position, got.status, got.read_value,
                                 got.entry_count, got.cursor_position);
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_cursor_edges();
        test_fill_and_drain(3);
        test_random_mix(270);
        s_tvalid <= 1'b0;
        // drain outstanding replies, then allow for the pipeline
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (error_count == 0 && expected_replies.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
